// ===== sv/ctl_pkg.sv =====
// Shared types and constants for the compacting tagged list.
// No dependencies; every other file imports this package.
package ctl_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam int KIND_W   = 3;
  localparam int CODE_W   = 8;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [KIND_W-1:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_COUNT  = 3'd3,
    OP_LIST   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BADPOS   = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OUT_FILL,
    OUT_PEND,
    OUT_ENTRY,
    OUT_COUNT
  } out_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_WK_RD,
    S_WK_EV
  } state_t;

  typedef struct packed {
    logic              take;
    logic              append;
    logic              idx_clear;
    logic              idx_load_pos;
    logic              idx_inc;
    logic              rd_en;
    logic              rd_next;
    logic              wr_shift;
    logic              fill_dec;
    logic              tally_inc;
    logic              pend_load;
    logic              out_load;
    out_sel_t          out_sel;
    status_t           out_status;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [KIND_W-1:0] in_kind;
    logic              full;
    logic              pos_bad;
    logic              shift_more;
    logic              walk_more;
    logic              last_entry;
    logic              match;
    logic              have_hits;
    logic              out_free;
  } sts_t;

endpackage

// ===== sv/ctl_ifs.sv =====
// Valid/ready channel interfaces for the compacting tagged list.
// Depends on ctl_pkg for field widths.
interface ctl_in_if;
  import ctl_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] item_code;
  logic [POS_W-1:0]  position;

  modport source (output valid, kind, item_code, position, input ready);
  modport sink   (input valid, kind, item_code, position, output ready);
endinterface

interface ctl_out_if;
  import ctl_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    found_position;
  logic [CODE_W-1:0]   entry_code;
  logic [POS_W-1:0]    match_count;
  logic                last;

  modport source (output valid, status, found_position, entry_code, match_count, last,
                  input ready);
  modport sink   (input valid, status, found_position, entry_code, match_count, last,
                  output ready);
endinterface

// ===== sv/ctl_dpath.sv =====
// Datapath: entry memory, fill level, walk index, tallies and the result register.
// Depends on ctl_pkg and ctl_ifs; driven by commands from ctl_ctrl.
module ctl_dpath (
  input  logic          clk,
  input  logic          rst,
  input  ctl_pkg::cmd_t cmd,
  output ctl_pkg::sts_t sts,
  ctl_in_if.sink        req,
  ctl_out_if.source     rsp
);
  import ctl_pkg::*;

  logic [CODE_W-1:0] mem [CAPACITY];
  logic [CODE_W-1:0] rdata;
  logic [CODE_W-1:0] qcode;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_plus1;
  logic [CNT_W-1:0]  tally;
  logic [CNT_W-1:0]  pend;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  fill_ext;
  logic [CNT_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  wr_addr;
  logic [CODE_W-1:0] wr_data;
  logic              wr_en;
  logic              accept;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_pos;
  logic [CODE_W-1:0]   out_code;
  logic [POS_W-1:0]    out_cnt;
  logic                out_last;
  logic [POS_W-1:0]    res_pos;
  logic [CODE_W-1:0]   res_code;
  logic [POS_W-1:0]    res_cnt;

  assign accept    = cmd.take && req.valid;
  assign req.ready = cmd.take;
  assign idx_plus1 = idx + CNT_W'(1);
  assign pos_ext   = CMP_W'(req.position);
  assign fill_ext  = CMP_W'(fill);

  always_comb begin
    fill_next = fill;
    if (cmd.append) begin
      fill_next = fill + CNT_W'(1);
    end else if (cmd.fill_dec) begin
      fill_next = fill - CNT_W'(1);
    end
  end

  // status toward the controller
  always_comb begin
    sts.in_valid   = req.valid;
    sts.in_kind    = req.kind;
    sts.full       = (fill == CNT_W'(CAPACITY));
    sts.pos_bad    = (pos_ext == '0) || (pos_ext > fill_ext);
    sts.shift_more = (idx_plus1 < fill);
    sts.walk_more  = (idx < fill);
    sts.last_entry = (idx_plus1 == fill);
    sts.match      = (rdata == qcode);
    sts.have_hits  = (tally != '0);
    sts.out_free   = !out_valid || rsp.ready;
  end

  // memory ports: append writes at the tail, a shift copies entry idx+1 down to idx
  assign rd_addr = cmd.rd_next ? idx_plus1 : idx;
  assign wr_en   = cmd.append || cmd.wr_shift;
  assign wr_addr = cmd.append ? fill : idx;
  assign wr_data = cmd.append ? req.item_code : rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qcode <= req.item_code;
    end
    if (cmd.idx_clear) begin
      idx   <= '0;
      tally <= '0;
    end else if (cmd.idx_load_pos) begin
      idx <= CNT_W'(req.position) - CNT_W'(1);
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx_plus1;
      end
      if (cmd.tally_inc) begin
        tally <= tally + CNT_W'(1);
      end
    end
    if (cmd.pend_load) begin
      pend <= idx_plus1;
    end
  end

  always_comb begin
    res_pos  = '0;
    res_code = '0;
    res_cnt  = POS_W'(fill);
    case (cmd.out_sel)
      OUT_FILL:  res_cnt = POS_W'(fill_next);
      OUT_PEND:  res_pos = POS_W'(pend);
      OUT_ENTRY: begin
        res_pos  = POS_W'(idx_plus1);
        res_code = rdata;
      end
      OUT_COUNT: res_cnt = POS_W'(tally);
      default:   res_cnt = POS_W'(fill);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      out_pos    <= res_pos;
      out_code   <= res_code;
      out_cnt    <= res_cnt;
      out_last   <= cmd.out_last;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.found_position = out_pos;
  assign rsp.entry_code     = out_code;
  assign rsp.match_count    = out_cnt;
  assign rsp.last           = out_last;

endmodule

// ===== sv/ctl_ctrl.sv =====
// Controller state machine: decodes each item and sequences shifts and walks.
// Depends on ctl_pkg; talks to ctl_dpath through cmd_t and sts_t.
module ctl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  ctl_pkg::sts_t sts,
  output ctl_pkg::cmd_t cmd
);
  import ctl_pkg::*;

  state_t state;
  state_t state_next;
  op_t    walk_op;
  op_t    walk_op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      walk_op <= OP_LIST;
    end else begin
      state   <= state_next;
      walk_op <= walk_op_next;
    end
  end

  always_comb begin
    state_next   = state;
    walk_op_next = walk_op;
    cmd          = '0;
    cmd.out_sel    = OUT_FILL;
    cmd.out_status = STAT_OK;
    cmd.out_last   = 1'b1;

    case (state)
      S_IDLE: begin
        cmd.take = sts.out_free;
        if (sts.in_valid && sts.out_free) begin
          case (sts.in_kind)
            OP_APPEND: begin
              cmd.out_load = 1'b1;
              if (sts.full) begin
                cmd.out_status = STAT_FULL;
              end else begin
                cmd.append = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (sts.pos_bad) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = STAT_BADPOS;
              end else begin
                cmd.idx_load_pos = 1'b1;
                state_next       = S_SH_RD;
              end
            end
            OP_SEARCH, OP_COUNT, OP_LIST: begin
              cmd.idx_clear = 1'b1;
              walk_op_next  = op_t'(sts.in_kind);
              state_next    = S_WK_RD;
            end
            default: cmd.out_load = 1'b1;
          endcase
        end
      end

      S_SH_RD: begin
        if (sts.shift_more) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = S_SH_WR;
        end else if (sts.out_free) begin
          cmd.fill_dec = 1'b1;
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_SH_RD;
      end

      S_WK_RD: begin
        if (sts.walk_more) begin
          cmd.rd_en  = 1'b1;
          state_next = S_WK_EV;
        end else if (walk_op == OP_LIST && sts.have_hits) begin
          // every entry already went out, the final one flagged last
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
          case (walk_op)
            OP_SEARCH: begin
              if (sts.have_hits) begin
                cmd.out_sel = OUT_PEND;
              end else begin
                cmd.out_status = STAT_NOTFOUND;
              end
            end
            OP_COUNT: cmd.out_sel = OUT_COUNT;
            default:  cmd.out_sel = OUT_FILL;
          endcase
        end
      end

      S_WK_EV: begin
        case (walk_op)
          OP_SEARCH: begin
            // hold each hit back one step so the final one can carry last
            if (!sts.match) begin
              cmd.idx_inc = 1'b1;
              state_next  = S_WK_RD;
            end else if (!sts.have_hits || sts.out_free) begin
              cmd.out_load  = sts.have_hits;
              cmd.out_sel   = OUT_PEND;
              cmd.out_last  = 1'b0;
              cmd.pend_load = 1'b1;
              cmd.tally_inc = 1'b1;
              cmd.idx_inc   = 1'b1;
              state_next    = S_WK_RD;
            end
          end
          OP_COUNT: begin
            cmd.tally_inc = sts.match;
            cmd.idx_inc   = 1'b1;
            state_next    = S_WK_RD;
          end
          default: begin
            if (sts.out_free) begin
              cmd.out_load  = 1'b1;
              cmd.out_sel   = OUT_ENTRY;
              cmd.out_last  = sts.last_entry;
              // count listed entries so the walk end can tell an empty list
              cmd.tally_inc = 1'b1;
              cmd.idx_inc   = 1'b1;
              state_next    = S_WK_RD;
            end
          end
        endcase
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/compacting_tagged_list_core.sv =====
// Top level of the compacting tagged list: controller plus datapath.
// Depends on ctl_pkg, ctl_ifs, ctl_ctrl and ctl_dpath.
//
// Ordered list of up to CAPACITY (16) 8-bit type codes, one item at a time.
// Append, a rejected append or remove, and undefined kinds finish in S_IDLE.
// Remove at position p shifts each later entry down via S_SH_RD and S_SH_WR;
// search, count and list walk every entry via S_WK_RD and S_WK_EV. The entry
// memory has one read and one write port with a registered read, so every entry
// visited costs a read state and a compare or write state. Results sit in an
// output register; a new item is taken once that register is free or being
// drained, and a held result stalls the walk until it is taken. No clearing pass after reset.
module compacting_tagged_list_core (
  input  logic      clk,
  input  logic      rst,
  ctl_in_if.sink    req,
  ctl_out_if.source rsp
);
  import ctl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ctl_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  ctl_dpath u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule
